>>> hw/rtl/e2q_pkg.sv
// ----------------------------------------------------------------------------
// e2q_pkg
// Shared types and constants for the Euler to quaternion core.
// ----------------------------------------------------------------------------
package e2q_pkg;

    localparam int unsigned IN_W        = 26;
    localparam int unsigned OUT_W       = 32;
    localparam int unsigned STAGES      = 30;
    localparam int unsigned CW          = 33;
    localparam logic signed [CW-1:0] GAIN_Q30 = 33'sd652032874;
    localparam logic signed [CW-1:0] ONE_Q30  = 33'sd1073741824;
    localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;

    typedef logic signed [IN_W-1:0] t_angle;
    typedef logic signed [CW-1:0]   t_q30;

    typedef struct packed {
        t_q30 s;
        t_q30 c;
    } t_sincos;

    // arctangent table, q30 radians
    function automatic t_q30 atan_q30(input logic [4:0] i);
        t_q30 v;
        unique case (i)
            5'd0: v = 33'sd843314857;   5'd1: v = 33'sd497837829;
            5'd2: v = 33'sd263043837;   5'd3: v = 33'sd133525159;
            5'd4: v = 33'sd67021687;    5'd5: v = 33'sd33543516;
            5'd6: v = 33'sd16775851;    5'd7: v = 33'sd8388437;
            5'd8: v = 33'sd4194283;     5'd9: v = 33'sd2097149;
            default: v = t_q30'(33'sd1 <<< (5'd30 - i));
        endcase
        return v;
    endfunction

endpackage

>>> hw/rtl/e2q_if.sv
// ----------------------------------------------------------------------------
// e2q_in_if / e2q_out_if
// Valid/ready channels for angle items and quaternion items.
// ----------------------------------------------------------------------------
interface e2q_in_if;
    logic               valid;
    logic               ready;
    logic signed [25:0] roll_deg;
    logic signed [25:0] pitch_deg;
    logic signed [25:0] yaw_deg;
    modport source (output valid, roll_deg, pitch_deg, yaw_deg, input ready);
    modport sink   (input valid, roll_deg, pitch_deg, yaw_deg, output ready);
endinterface

interface e2q_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] quat_w;
    logic signed [31:0] quat_x;
    logic signed [31:0] quat_y;
    logic signed [31:0] quat_z;
    modport source (output valid, quat_w, quat_x, quat_y, quat_z, input ready);
    modport sink   (input valid, quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

>>> hw/rtl/euler_to_quaternion_core.sv
// ----------------------------------------------------------------------------
// euler_to_quaternion_core
// ZYX Euler angles in degrees to a unit quaternion in fixed point.
// ----------------------------------------------------------------------------
// Takes one transfer per cycle while not stalled and gives one quaternion per
// item. Each of the three angle lanes has phase conversion stages a to d, 30
// cordic stages and 1 fold stage; then come 3 merge stages, the last of which
// is the output register. The whole pipeline advances together and stalls
// only when the output register holds a result that the sink has not taken.
module euler_to_quaternion_core
    import e2q_pkg::*;
#(
    parameter int unsigned ANGLE_FRAC_BITS = 16,
    parameter int unsigned QUAT_FRAC_BITS  = 30
) (
    input  logic i_clk,
    input  logic i_rst_n,
    e2q_in_if.sink    i_in,
    e2q_out_if.source o_out
);
    localparam int unsigned LAT = 4 + STAGES + 1 + 3;

    // pipeline advances unless the output slot is full and stalled
    logic w_en;
    logic [LAT-1:0] r_vld;
    assign w_en = !o_out.valid || o_out.ready;
    assign i_in.ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAT-2:0], i_in.valid};
        end
    end
    assign o_out.valid = r_vld[LAT-1];

    // angle lanes
    t_sincos w_sc [3];
    t_angle  w_deg [3];
    assign w_deg[0] = i_in.roll_deg;
    assign w_deg[1] = i_in.pitch_deg;
    assign w_deg[2] = i_in.yaw_deg;
    for (genvar l = 0; l < 3; l++) begin : g_lane
        e2q_lane #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_lane (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_deg (w_deg[l]),
            .o_sc  (w_sc[l])
        );
    end

    // merge
    logic signed [OUT_W-1:0] w_q [4];
    e2q_merge #(.QUAT_FRAC_BITS(QUAT_FRAC_BITS)) u_merge (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_r   (w_sc[0]),
        .i_p   (w_sc[1]),
        .i_y   (w_sc[2]),
        .o_q   (w_q)
    );
    assign o_out.quat_w = w_q[0];
    assign o_out.quat_x = w_q[1];
    assign o_out.quat_y = w_q[2];
    assign o_out.quat_z = w_q[3];
endmodule

>>> hw/rtl/e2q_lane.sv
// ----------------------------------------------------------------------------
// e2q_lane
// One angle lane: degrees to half-angle phase, then a 30-stage pipelined
// cordic giving clamped sine and cosine in q30. Advances when i_en is high.
// ----------------------------------------------------------------------------
module e2q_lane
    import e2q_pkg::*;
#(
    parameter int unsigned ANGLE_FRAC_BITS = 16
) (
    input  logic    i_clk,
    input  logic    i_en,
    input  t_angle  i_deg,
    output t_sincos o_sc
);
    // phase = round(mag * 2^(28-AFB) / 45), since 720 * 2^AFB = 45 * 2^(AFB+4)
    localparam int unsigned K = 28 - ANGLE_FRAC_BITS;
    // reciprocal of 45 in 2^32 scale, exact floor for dividends below 2^26
    localparam logic [26:0] RECIP45 = 27'd95443718;

    // stage a: magnitude and sign
    logic [IN_W-1:0] r_mag;
    logic            r_neg;
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_neg <= i_deg[IN_W-1];
            r_mag <= i_deg[IN_W-1] ? IN_W'(-i_deg) : IN_W'(i_deg);
        end
    end

    // stage b: whole multiples of 45 by reciprocal multiply
    logic [52:0]     n_prod;
    logic [19:0]     r_quo;
    logic [IN_W-1:0] r_mag_b;
    logic            r_neg_b;
    assign n_prod = 53'(r_mag) * 53'(RECIP45);
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_quo   <= n_prod[51:32];
            r_mag_b <= r_mag;
            r_neg_b <= r_neg;
        end
    end

    // stage c: scaled quotient plus rounded share of the remainder, apply sign
    logic [31:0]     w_frac [45];
    logic [IN_W-1:0] n_rem;
    logic [5:0]      n_b;
    logic [63:0]     n_hi;
    logic [31:0]     n_q;
    logic [31:0]     r_phase;
    for (genvar j = 0; j < 45; j++) begin : g_frac
        assign w_frac[j] = 32'(((64'(j) << K) + 64'd22) / 64'd45);
    end
    always_comb begin
        n_rem = r_mag_b - IN_W'(r_quo) * IN_W'(45);
        n_b   = n_rem[5:0];
        n_hi  = 64'(r_quo) << K;
        n_q   = n_hi[31:0] + w_frac[n_b];
    end
    always_ff @(posedge i_clk) begin
        if (i_en)
            r_phase <= r_neg_b ? 32'(-n_q) : n_q;
    end

    // stage d: residue to q30 radians
    logic [61:0] n_zp;
    t_q30        r_z0;
    logic [1:0]  r_quad0;
    assign n_zp = 62'(r_phase[29:0]) * 62'(HALF_PI_Q30) + (62'd1 << 29);
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_z0    <= t_q30'(n_zp >> 30);
            r_quad0 <= r_phase[31:30];
        end
    end

    // cordic rotation stages
    t_q30       r_x [1:STAGES];
    t_q30       r_y [1:STAGES];
    t_q30       r_z [1:STAGES];
    logic [1:0] r_q [1:STAGES];
    for (genvar g = 0; g < STAGES; g++) begin : g_stage
        t_q30       w_xi;
        t_q30       w_yi;
        t_q30       w_zi;
        logic [1:0] w_qi;
        if (g == 0) begin : g_first
            assign w_xi = GAIN_Q30;
            assign w_yi = '0;
            assign w_zi = r_z0;
            assign w_qi = r_quad0;
        end else begin : g_next
            assign w_xi = r_x[g];
            assign w_yi = r_y[g];
            assign w_zi = r_z[g];
            assign w_qi = r_q[g];
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_q[g+1] <= w_qi;
                if (!w_zi[CW-1]) begin
                    r_x[g+1] <= w_xi - (w_yi >>> g);
                    r_y[g+1] <= w_yi + (w_xi >>> g);
                    r_z[g+1] <= w_zi - atan_q30(5'(g));
                end else begin
                    r_x[g+1] <= w_xi + (w_yi >>> g);
                    r_y[g+1] <= w_yi - (w_xi >>> g);
                    r_z[g+1] <= w_zi + atan_q30(5'(g));
                end
            end
        end
    end

    // quadrant fold and clamp
    t_q30 n_s, n_c;
    function automatic t_q30 clamp(input t_q30 v);
        if (v > ONE_Q30)       return ONE_Q30;
        else if (v < -ONE_Q30) return -ONE_Q30;
        else                   return v;
    endfunction
    always_comb begin
        unique case (r_q[STAGES])
            2'd0: begin n_c = r_x[STAGES];  n_s = r_y[STAGES];  end
            2'd1: begin n_c = -r_y[STAGES]; n_s = r_x[STAGES];  end
            2'd2: begin n_c = -r_x[STAGES]; n_s = -r_y[STAGES]; end
            default: begin n_c = r_y[STAGES]; n_s = -r_x[STAGES]; end
        endcase
    end
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_sc.s <= clamp(n_s);
            o_sc.c <= clamp(n_c);
        end
    end
endmodule

>>> hw/rtl/e2q_merge.sv
// ----------------------------------------------------------------------------
// e2q_merge
// Combines the three lanes' sine and cosine into the quaternion: q30 pair
// products, q60 triple products, sums, rounding and saturation.
// ----------------------------------------------------------------------------
module e2q_merge
    import e2q_pkg::*;
#(
    parameter int unsigned QUAT_FRAC_BITS = 30
) (
    input  logic                    i_clk,
    input  logic                    i_en,
    input  t_sincos                 i_r,
    input  t_sincos                 i_p,
    input  t_sincos                 i_y,
    output logic signed [OUT_W-1:0] o_q [4]
);
    localparam int unsigned SH = 60 - QUAT_FRAC_BITS;
    localparam logic signed [63:0] LIM = 64'sd1 <<< QUAT_FRAC_BITS;

    // stage 1: pair products back to q30
    function automatic t_q30 mq(input t_q30 a, input t_q30 b);
        logic signed [65:0] p;
        p = 66'(a) * 66'(b) + (66'sd1 <<< 29);
        return t_q30'(p >>> 30);
    endfunction
    t_q30 r_crcp, r_srsp, r_srcp, r_crsp, r_sy, r_cy;
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_crcp <= mq(i_r.c, i_p.c);
            r_srsp <= mq(i_r.s, i_p.s);
            r_srcp <= mq(i_r.s, i_p.c);
            r_crsp <= mq(i_r.c, i_p.s);
            r_sy   <= i_y.s;
            r_cy   <= i_y.c;
        end
    end

    // stage 2: triple products in q60
    logic signed [65:0] r_t [8];
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_t[0] <= 66'(r_crcp) * 66'(r_cy);
            r_t[1] <= 66'(r_srsp) * 66'(r_sy);
            r_t[2] <= 66'(r_srcp) * 66'(r_cy);
            r_t[3] <= 66'(r_crsp) * 66'(r_sy);
            r_t[4] <= 66'(r_crsp) * 66'(r_cy);
            r_t[5] <= 66'(r_srcp) * 66'(r_sy);
            r_t[6] <= 66'(r_crcp) * 66'(r_sy);
            r_t[7] <= 66'(r_srsp) * 66'(r_cy);
        end
    end

    // stage 3: sums, round and saturate
    function automatic logic signed [OUT_W-1:0] fin(input logic signed [65:0] v);
        logic signed [65:0] r;
        r = (v + (66'sd1 <<< (SH - 1))) >>> SH;
        if (r > 66'(LIM))       return OUT_W'(LIM);
        else if (r < -66'(LIM)) return OUT_W'(-LIM);
        else                    return OUT_W'(r);
    endfunction
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_q[0] <= fin(r_t[0] + r_t[1]);
            o_q[1] <= fin(r_t[2] - r_t[3]);
            o_q[2] <= fin(r_t[4] + r_t[5]);
            o_q[3] <= fin(r_t[6] - r_t[7]);
        end
    end
endmodule

>>> hw/rtl/e2q_checker.sv
// ----------------------------------------------------------------------------
// e2q_checker
// Port-level checks on the quaternion output channel and the input ready.
// ----------------------------------------------------------------------------
module e2q_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic signed [31:0] i_out_w,
    input logic signed [31:0] i_out_x
);
    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_w) && $stable(i_out_x))
        else $error("output changed while stalled");

    // input is taken whenever output slot is free
    a_rdy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("ready low with empty output");

    // quat_w stays within unit range
    a_rng: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_out_w <= 32'sd1073741824 && i_out_w >= -32'sd1073741824)
        else $error("quat_w out of range");

    // no output right after reset
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("valid after reset");
endmodule

bind euler_to_quaternion_core e2q_checker u_e2q_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_w     (o_out.quat_w),
    .i_out_x     (o_out.quat_x)
);
